### rtl/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// lzwe_pkg
// Shared constants and types for the LZW byte encoder: dictionary geometry,
// the packed dictionary node word and the result item record.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    // Dictionary geometry
    localparam int DICT_SIZE  = 4096;
    localparam int ADDR_W     = $clog2(DICT_SIZE);
    localparam int ROOT_CODES = 256;
    localparam int ROOT_W     = $clog2(ROOT_CODES);
    localparam int BYTE_W     = 8;
    localparam int NFC_W      = ADDR_W + 1;

    // Emitted code width and the byte-padded stream word
    localparam int CODE_W     = 12;
    localparam int OUT_DATA_W = ((CODE_W + 7) / 8) * 8;

    // A link of zero means no child or no sibling: roots are never linked to
    localparam logic [ADDR_W-1:0] LINK_NONE = '0;

    // One dictionary entry, stored as a single memory word
    typedef struct packed {
        logic [BYTE_W-1:0] suffix;
        logic [ADDR_W-1:0] first_child;
        logic [ADDR_W-1:0] next_sibling;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Result item handed from the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              last;
    } out_item_t;

endpackage

### rtl/lzw_byte_encoder.sv
// ----------------------------------------------------------------------------
// lzw_byte_encoder
// Byte-in LZW encoder with fixed 12-bit codes. The dictionary is a
// first-child / next-sibling tree kept in one node memory; a sequencer walks
// the child list of the current prefix one node per cycle.
// Each byte is taken only while the sequencer is idle, so a new byte waits
// until the last one is through. The first byte of a stream only opens the
// prefix; any other byte reads the prefix node, walks its siblings and, on a
// miss, emits the prefix and, while there is room, writes and links a new
// leaf; node reads use the memory's registered read port. A final flush
// emits the last prefix; a code enters the output register once it is free.
// Reset: asynchronous, active low; the root valid bits clear at once, so no
// clearing pass is needed; the dictionary restarts at the end of each stream.
// ----------------------------------------------------------------------------
module lzw_byte_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tlast,  // end_of_stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lzwe_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [11:0] code
    output logic                            m_axis_tlast   // last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PFX,
        S_WALK,
        S_MISS,
        S_LINK,
        S_FLUSH
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [lzwe_pkg::BYTE_W-1:0]     byte_reg;
    logic [lzwe_pkg::BYTE_W-1:0]     byte_next;
    logic                            eos_reg;
    logic                            eos_next;
    logic [lzwe_pkg::ADDR_W-1:0]     prefix_reg;
    logic [lzwe_pkg::ADDR_W-1:0]     prefix_next;
    logic                            prefix_valid_reg;
    logic                            prefix_valid_next;
    logic [lzwe_pkg::NFC_W-1:0]      nfc_reg;
    logic [lzwe_pkg::NFC_W-1:0]      nfc_next;
    logic [lzwe_pkg::ADDR_W-1:0]     node_reg;
    logic [lzwe_pkg::ADDR_W-1:0]     node_next;
    lzwe_pkg::node_t                 link_word_reg;
    lzwe_pkg::node_t                 link_word_next;
    logic [lzwe_pkg::ADDR_W-1:0]     link_addr_reg;
    logic [lzwe_pkg::ADDR_W-1:0]     link_addr_next;
    logic                            link_tail_reg;
    logic                            link_tail_next;

    logic                            in_accept;
    logic                            ram_we;
    logic [lzwe_pkg::ADDR_W-1:0]     ram_waddr;
    lzwe_pkg::node_t                 ram_wdata;
    logic [lzwe_pkg::ADDR_W-1:0]     ram_raddr;
    lzwe_pkg::node_t                 ram_rdata;
    logic [lzwe_pkg::NODE_W-1:0]     ram_rdata_raw;
    logic                            prefix_is_root;
    logic                            root_valid;
    logic                            root_set;
    logic                            root_clear;
    logic [lzwe_pkg::ADDR_W-1:0]     pfx_child;
    logic [lzwe_pkg::ADDR_W-1:0]     fresh_code;
    logic                            dict_room;
    logic                            push_ready;
    lzwe_pkg::out_item_t             push;
    state_t                          after_item;

    assign s_axis_tready  = (state_reg == S_IDLE);
    assign in_accept      = s_axis_tvalid && s_axis_tready;
    assign ram_rdata      = lzwe_pkg::node_t'(ram_rdata_raw);
    assign prefix_is_root = (prefix_reg[lzwe_pkg::ADDR_W-1:lzwe_pkg::ROOT_W] == '0);
    assign fresh_code     = nfc_reg[lzwe_pkg::ADDR_W-1:0];
    assign dict_room      = (nfc_reg < lzwe_pkg::NFC_W'(lzwe_pkg::DICT_SIZE));
    assign after_item     = eos_reg ? S_FLUSH : S_IDLE;

    // A root's child link counts only once its valid bit is set
    assign pfx_child = (prefix_is_root && !root_valid) ? lzwe_pkg::LINK_NONE
                                                       : ram_rdata.first_child;

    // Node memory: suffix and both links of every code
    lzwe_ram #(
        .WIDTH (lzwe_pkg::NODE_W),
        .DEPTH (lzwe_pkg::DICT_SIZE)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    lzwe_root_tbl u_root_tbl (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (root_clear),
        .set      (root_set),
        .set_idx  (prefix_reg[lzwe_pkg::ROOT_W-1:0]),
        .rd_idx   (prefix_reg[lzwe_pkg::ROOT_W-1:0]),
        .rd_valid (root_valid)
    );

    lzwe_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_ready    (push_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Sequence one item: read prefix, walk siblings, emit on a miss and learn
    // while there is room, flush at stream end. Writes and the reads that depend
    // on them fall in different cycles, so no forwarding is needed.
    always_comb
    begin
        state_next        = state_reg;
        byte_next         = byte_reg;
        eos_next          = eos_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        nfc_next          = nfc_reg;
        node_next         = node_reg;
        link_word_next    = link_word_reg;
        link_addr_next    = link_addr_reg;
        link_tail_next    = link_tail_reg;
        ram_we            = 1'b0;
        ram_waddr         = fresh_code;
        ram_wdata         = link_word_reg;
        ram_raddr         = prefix_reg;
        root_set          = 1'b0;
        root_clear        = 1'b0;
        push.valid        = 1'b0;
        push.code         = lzwe_pkg::CODE_W'(prefix_reg);
        push.last         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    byte_next = s_axis_tdata;
                    eos_next  = s_axis_tlast;
                    if (!prefix_valid_reg)
                    begin
                        // First byte of a stream becomes the prefix
                        prefix_next       = lzwe_pkg::ADDR_W'(s_axis_tdata);
                        prefix_valid_next = 1'b1;
                        state_next        = s_axis_tlast ? S_FLUSH : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PFX;
                    end
                end
            end

            S_PFX:
            begin
                link_word_next             = ram_rdata;
                link_word_next.first_child = pfx_child;
                link_addr_next             = prefix_reg;
                link_tail_next             = 1'b0;
                if (pfx_child == lzwe_pkg::LINK_NONE)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    ram_raddr  = pfx_child;
                    node_next  = pfx_child;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (ram_rdata.suffix == byte_reg)
                begin
                    // Hit: extend the prefix
                    prefix_next = node_reg;
                    state_next  = after_item;
                end
                else if (ram_rdata.next_sibling == lzwe_pkg::LINK_NONE)
                begin
                    link_word_next = ram_rdata;
                    link_addr_next = node_reg;
                    link_tail_next = 1'b1;
                    state_next     = S_MISS;
                end
                else
                begin
                    ram_raddr = ram_rdata.next_sibling;
                    node_next = ram_rdata.next_sibling;
                end
            end

            S_MISS:
            begin
                if (push_ready)
                begin
                    push.valid = 1'b1;
                    if (dict_room)
                    begin
                        // Write the new leaf
                        ram_we                 = 1'b1;
                        ram_waddr              = fresh_code;
                        ram_wdata.suffix       = byte_reg;
                        ram_wdata.first_child  = lzwe_pkg::LINK_NONE;
                        ram_wdata.next_sibling = lzwe_pkg::LINK_NONE;
                        state_next             = S_LINK;
                    end
                    else
                    begin
                        prefix_next = lzwe_pkg::ADDR_W'(byte_reg);
                        state_next  = after_item;
                    end
                end
            end

            S_LINK:
            begin
                // Hook the new leaf under its parent or after the last sibling
                ram_we    = 1'b1;
                ram_waddr = link_addr_reg;
                if (link_tail_reg)
                begin
                    ram_wdata.next_sibling = fresh_code;
                end
                else
                begin
                    ram_wdata.first_child = fresh_code;
                    root_set              = prefix_is_root;
                end
                nfc_next    = nfc_reg + 1'b1;
                prefix_next = lzwe_pkg::ADDR_W'(byte_reg);
                state_next  = after_item;
            end

            S_FLUSH:
            begin
                push.last = 1'b1;
                if (push_ready)
                begin
                    // Emit the final prefix and start a fresh dictionary
                    push.valid        = 1'b1;
                    root_clear        = 1'b1;
                    prefix_next       = '0;
                    prefix_valid_next = 1'b0;
                    nfc_next          = lzwe_pkg::NFC_W'(lzwe_pkg::ROOT_CODES);
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            nfc_reg          <= lzwe_pkg::NFC_W'(lzwe_pkg::ROOT_CODES);
            eos_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            nfc_reg          <= nfc_next;
            eos_reg          <= eos_next;
        end
    end

    // Working payload needs no reset
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        node_reg      <= node_next;
        link_word_reg <= link_word_next;
        link_addr_reg <= link_addr_next;
        link_tail_reg <= link_tail_next;
    end

    // Free-code counter stays between the roots and the dictionary size
    a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nfc_reg >= lzwe_pkg::NFC_W'(lzwe_pkg::ROOT_CODES)) &&
        (nfc_reg <= lzwe_pkg::NFC_W'(lzwe_pkg::DICT_SIZE)))
        else $error("free code counter out of range");

    // Learning never writes once the dictionary is full
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> dict_room)
        else $error("dictionary write with no free code");

    // The sibling walk only visits learned codes
    a_walk_learned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |->
            (node_reg >= lzwe_pkg::ADDR_W'(lzwe_pkg::ROOT_CODES)) &&
            (nfc_reg > lzwe_pkg::NFC_W'(node_reg)))
        else $error("walk reached an unlearned code");

    // A delivered flush leaves the block as after reset
    a_flush_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && push_ready) |=>
            (!prefix_valid_reg && nfc_reg == lzwe_pkg::NFC_W'(lzwe_pkg::ROOT_CODES)))
        else $error("stream end did not restart the dictionary");

endmodule

### rtl/lzwe_ram.sv
// ----------------------------------------------------------------------------
// lzwe_ram
// Generic single-clock RAM with one write port and one read port. Read data
// is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module lzwe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lzwe_root_tbl.sv
// ----------------------------------------------------------------------------
// lzwe_root_tbl
// Valid bits for the first-child links of the 256 root codes. A root whose
// bit is clear has no children, whatever its memory word holds. All bits
// clear at reset and at the end of each stream.
// ----------------------------------------------------------------------------
module lzwe_root_tbl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       set,
    input  logic [lzwe_pkg::ROOT_W-1:0] set_idx,
    input  logic [lzwe_pkg::ROOT_W-1:0] rd_idx,
    output logic                       rd_valid
);

    logic [lzwe_pkg::ROOT_CODES-1:0] valid_reg;
    logic [lzwe_pkg::ROOT_CODES-1:0] valid_next;

    // Clear the whole table at end of stream, else mark one root
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (set)
        begin
            valid_next[set_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rd_valid = valid_reg[rd_idx];

endmodule

### rtl/lzwe_out_stage.sv
// ----------------------------------------------------------------------------
// lzwe_out_stage
// Output register for result items. Takes a new item whenever it is empty
// or its held item leaves in the same cycle.
// ----------------------------------------------------------------------------
module lzwe_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lzwe_pkg::out_item_t             push,
    output logic                            push_ready,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lzwe_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [11:0] code, rest zero
    output logic                            m_axis_tlast   // last
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [lzwe_pkg::CODE_W-1:0]   code_reg;
    logic                          last_reg;

    assign push_ready = !valid_reg || m_axis_tready;

    // Load on push, drop when the held item is taken
    always_comb
    begin
        valid_next = valid_reg;
        if (push.valid && push_ready)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds until replaced
    always_ff @(posedge clk)
    begin
        if (push.valid && push_ready)
        begin
            code_reg <= push.code;
            last_reg <= push.last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = lzwe_pkg::OUT_DATA_W'(code_reg);
    assign m_axis_tlast  = last_reg;

endmodule

### test/lzw_byte_encoder_checker.sv
// ----------------------------------------------------------------------------
// lzw_byte_encoder_checker
// Watches both stream channels of the LZW byte encoder. Each accepted input
// item runs through a local dictionary tree, and the codes it produces are
// queued. Each accepted output item is compared field by field with the
// oldest queued code. Reports the mismatch count and the number of codes
// still owed by the block.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,    // [7:0] data_byte
    input  logic                            s_axis_tlast,    // end_of_stream
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [lzwe_pkg::OUT_DATA_W-1:0] m_axis_tdata,    // [11:0] code
    input  logic                            m_axis_tlast,    // last
    output int                              mismatch_count,
    output int                              codes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [lzwe_pkg::CODE_W-1:0] code;
        logic                        last;
    } code_item_t;

    // Local copy of the dictionary tree and the encoder position
    logic [lzwe_pkg::BYTE_W-1:0] dict_suffix  [lzwe_pkg::DICT_SIZE];
    int unsigned                 dict_child   [lzwe_pkg::DICT_SIZE];
    int unsigned                 dict_sibling [lzwe_pkg::DICT_SIZE];
    int unsigned                 free_code;
    int unsigned                 prefix_code;
    bit                          prefix_live;
    code_item_t                  due_codes [$];

    // Forget every learned code and drop the prefix
    function automatic void restart_dictionary();
        for (int i = 0; i < lzwe_pkg::DICT_SIZE; i++)
        begin
            dict_child[i]   = 0;
            dict_sibling[i] = 0;
        end
        free_code   = lzwe_pkg::ROOT_CODES;
        prefix_code = 0;
        prefix_live = 1'b0;
    endfunction

    function automatic void queue_code(input int unsigned code, input logic last);
        code_item_t item;
        item.code = lzwe_pkg::CODE_W'(code);
        item.last = last;
        due_codes.push_back(item);
    endfunction

    // Advance the encoder by one byte and queue the codes it emits
    function automatic void encode_byte(input logic [7:0] value, input logic eos);
        int unsigned node;
        int unsigned tail;
        int unsigned hit;
        int unsigned steps;
        if (!prefix_live)
        begin
            // first byte of a stream only opens the prefix
            prefix_code = 32'(value);
            prefix_live = 1'b1;
        end
        else
        begin
            node  = dict_child[prefix_code];
            tail  = 0;
            hit   = 0;
            steps = 0;
            // walk the child list of the prefix
            while (node != 0 && hit == 0 && steps < lzwe_pkg::DICT_SIZE)
            begin
                if (dict_suffix[node] == value)
                    hit = node;
                else
                begin
                    tail = node;
                    node = dict_sibling[node];
                end
                steps++;
            end
            if (hit != 0)
                prefix_code = hit;
            else
            begin
                queue_code(prefix_code, 1'b0);
                // learn the pair as the new last child while there is room
                if (free_code < lzwe_pkg::DICT_SIZE)
                begin
                    dict_suffix[free_code]  = value;
                    dict_child[free_code]   = 0;
                    dict_sibling[free_code] = 0;
                    if (tail != 0)
                        dict_sibling[tail] = free_code;
                    else
                        dict_child[prefix_code] = free_code;
                    free_code++;
                end
                prefix_code = 32'(value);
            end
        end
        // flush the remaining prefix and start over with a fresh dictionary
        if (eos)
        begin
            queue_code(prefix_code, 1'b1);
            restart_dictionary();
        end
    endfunction

    // Compare output items, then feed accepted input items to the encoder
    always @(posedge clk)
    begin
        code_item_t want;
        if (!rst_n)
        begin
            restart_dictionary();
            due_codes.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_codes.size() == 0)
                begin
                    $error("code %0d (last %0b) arrived with no code expected",
                           m_axis_tdata[lzwe_pkg::CODE_W-1:0], m_axis_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = due_codes.pop_front();
                    if (m_axis_tdata[lzwe_pkg::CODE_W-1:0] !== want.code)
                    begin
                        $error("code: expected %0d, got %0d",
                               want.code, m_axis_tdata[lzwe_pkg::CODE_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[lzwe_pkg::OUT_DATA_W-1:lzwe_pkg::CODE_W] !== '0)
                    begin
                        $error("tdata padding: expected 0, got %0h",
                               m_axis_tdata[lzwe_pkg::OUT_DATA_W-1:lzwe_pkg::CODE_W]);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                encode_byte(s_axis_tdata, s_axis_tlast);
        end
        codes_pending = due_codes.size();
    end

endmodule

### test/lzw_byte_encoder_tb.sv
// ----------------------------------------------------------------------------
// lzw_byte_encoder_tb
// Drives byte streams into the LZW byte encoder: a short directed set of
// streams, then random streams over narrow and wide byte alphabets. The
// sender works in random bursts and the receiver stalls on its own pattern,
// with one long receiver hold-off and two full drains. The checker instance
// predicts and compares the codes.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES  = 620;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 100;

    typedef enum int unsigned {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_e;

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata  = '0;    // [7:0] data_byte
    logic                            s_axis_tlast  = 1'b0;  // end_of_stream
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lzwe_pkg::OUT_DATA_W-1:0] m_axis_tdata;          // [11:0] code
    logic                            m_axis_tlast;          // last

    int          mismatch_count;
    int          codes_pending;
    int unsigned burst_left    = 0;
    int unsigned bytes_sent    = 0;
    bit          hold_request  = 1'b0;

    lzw_byte_encoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    lzw_byte_encoder_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .codes_pending  (codes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: switch between ready patterns, honor a long hold-off on request
    initial
    begin : rx_pattern
        int unsigned phase_left;
        int unsigned hold_left;
        rx_mode_e    rx_mode;
        phase_left = 0;
        hold_left  = 0;
        rx_mode    = RX_ALWAYS;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (phase_left == 0)
            begin
                rx_mode    = rx_mode_e'($urandom_range(0, 3));
                phase_left = $urandom_range(8, 80);
            end
            phase_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    // Offer one byte, inserting a random gap at the start of each burst
    task automatic send_byte(input logic [7:0] value, input logic eos);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_pattern(input logic [7:0] pattern [$]);
        foreach (pattern[i])
            send_byte(pattern[i], i == pattern.size() - 1);
    endtask

    // One stream of random bytes drawn from base with the masked bits varied
    task automatic send_random_stream(input int unsigned len, input logic [7:0] base,
                                      input logic [7:0] mask);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'(base ^ ($urandom() & mask)), i == len - 1);
    endtask

    // Stop offering and wait until every queued code has come out
    task automatic drain_codes();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (codes_pending == 0);
        @(posedge clk);
    endtask

    task automatic send_random_streams(input int unsigned count_to);
        int unsigned len;
        logic [7:0]  mask;
        while (bytes_sent < count_to)
        begin
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
            case ($urandom_range(0, 5))
                0:       mask = 8'h00;
                1:       mask = 8'h01;
                2:       mask = 8'h03;
                3:       mask = 8'h0F;
                4:       mask = 8'h3F;
                default: mask = 8'hFF;
            endcase
            send_random_stream(len, 8'($urandom()), mask);
        end
    endtask

    initial
    begin : stimulus
        logic [7:0]  pattern [$];
        int unsigned directed_end;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte streams at both byte extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // alternating pair: hits, misses and a two-entry child list
        pattern = '{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h41,
                    8'h41, 8'h41};
        send_pattern(pattern);
        pattern = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        send_pattern(pattern);
        pattern = '{8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80};
        send_pattern(pattern);
        directed_end = bytes_sent;

        // random streams, with a long receiver hold-off and a full drain
        send_random_streams(directed_end + 200);
        hold_request = 1'b1;
        send_random_streams(directed_end + 420);
        drain_codes();
        send_random_streams(directed_end + RANDOM_BYTES);

        drain_codes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/lzwe_pkg.sv
rtl/lzwe_ram.sv
rtl/lzwe_root_tbl.sv
rtl/lzwe_out_stage.sv
rtl/lzw_byte_encoder.sv
test/lzw_byte_encoder_checker.sv
test/lzw_byte_encoder_tb.sv
